FILE: src/sfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfp_pkg;

	// Frame framing bytes
	localparam logic [7:0] HDR_FIRST  = 8'h55;
	localparam logic [7:0] HDR_SECOND = 8'h54;
	localparam logic [7:0] END_MARK   = 8'hff;

	// Stored payload entries and result fields
	localparam int STORE_DEPTH = 8;
	localparam int STORE_AW    = 3;
	localparam int OUT_FIELDS  = 8;

	// Parser phases
	localparam logic [2:0] PH_HUNT    = 3'd0;
	localparam logic [2:0] PH_HDR2    = 3'd1;
	localparam logic [2:0] PH_LEN     = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_MARK    = 3'd4;
	localparam logic [2:0] PH_TRAIL1  = 3'd5;
	localparam logic [2:0] PH_TRAIL2  = 3'd6;
	localparam logic [2:0] PH_TRAIL3  = 3'd7;

	typedef logic [7:0] byte_t;

endpackage

`default_nettype wire

FILE: src/sonar_frame_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Sonar frame parser. Takes one received byte per item on the s_ side and
// hunts for a frame: 0x55, 0x54, a length byte equal to PAYLOAD_BYTES, the
// payload bytes, a 0xff marker and three unchecked trailing bytes. A wrong
// header, length or marker byte drops back to the hunt. The third trailing
// byte emits one item on the m_ side holding the first eight payload bytes
// (fields beyond PAYLOAD_BYTES read as zero). Bytes are taken one byte per
// cycle, but for the stall below; the result lands in the output register
// in the cycle after the last trailing byte is taken. The parser keeps taking
// bytes while a result waits downstream; only a frame-ending byte stalls,
// and only while the previous result is still held in the output register.
module sonar_frame_parser_core
	import sfp_pkg::*;
#(
	parameter int PAYLOAD_BYTES = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [63:0] m_tdata    // [7:0] payload_byte0 .. [63:56] payload_byte7
);

	localparam logic [3:0] PAY_CNT = 4'(PAYLOAD_BYTES);
	localparam logic [7:0] PAY_LEN = 8'(PAYLOAD_BYTES);

	logic [2:0]  phase_q;
	logic [3:0]  count_q;
	byte_t       store_q [STORE_DEPTH];
	logic        out_valid_q;
	logic [63:0] out_data_q;

	logic        s_acc;
	logic        emit;
	logic [2:0]  phase_d;
	logic [3:0]  count_inc;
	logic [63:0] result;

	// Only a frame-ending byte needs room in the output register
	assign s_tready  = (phase_q != PH_TRAIL3) || !out_valid_q || m_tready;
	assign s_acc     = s_tvalid && s_tready;
	assign emit      = s_acc && (phase_q == PH_TRAIL3);
	assign count_inc = count_q + 4'd1;

	// Next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HUNT:    phase_d = (s_tdata == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
			PH_HDR2:    phase_d = (s_tdata == HDR_SECOND) ? PH_LEN : PH_HUNT;
			PH_LEN:     phase_d = (s_tdata == PAY_LEN) ? PH_PAYLOAD : PH_HUNT;
			PH_PAYLOAD: phase_d = (count_inc == PAY_CNT) ? PH_MARK : PH_PAYLOAD;
			PH_MARK:    phase_d = (s_tdata == END_MARK) ? PH_TRAIL1 : PH_HUNT;
			PH_TRAIL1:  phase_d = PH_TRAIL2;
			PH_TRAIL2:  phase_d = PH_TRAIL3;
			default:    phase_d = PH_HUNT;
		endcase
	end

	// Result word from the stored payload
	always_comb begin
		for (int k = 0; k < OUT_FIELDS; k++) begin
			result[k*8 +: 8] = (k < PAYLOAD_BYTES) ? store_q[k] : 8'h00;
		end
	end

	// Parser control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= 4'd0;
		end else if (s_acc) begin
			phase_q <= phase_d;
			if (phase_q == PH_LEN) begin
				count_q <= 4'd0;
			end else if (phase_q == PH_PAYLOAD) begin
				count_q <= count_inc;
			end
		end
	end

	// Payload store; bytes past the eighth are counted only
	always_ff @(posedge clk) begin
		if (s_acc && phase_q == PH_PAYLOAD && count_q < 4'(STORE_DEPTH)) begin
			store_q[count_q[STORE_AW-1:0]] <= s_tdata;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Checks
	a_rise_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(s_acc && phase_q == PH_TRAIL3))
		else $error("result appeared without a frame-ending byte");

	a_emit_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (phase_q == PH_HUNT) && out_valid_q)
		else $error("frame end did not load result and restart hunt");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (count_q < PAY_CNT))
		else $error("payload count ran past frame length");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TRAIL3 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("frame end taken while result still held");

endmodule

`default_nettype wire

FILE: verif/sfp_frame_checker.sv
`timescale 1ns / 1ps

// Watches both stream channels of the sonar frame parser. Runs its own copy
// of the frame hunt on every accepted input item, queues the payload of each
// completed frame and compares it field by field with each accepted result.
module sfp_frame_checker
	import sfp_pkg::*;
#(
	parameter int PAYLOAD_BYTES = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [63:0] m_tdata,   // [7:0] payload_byte0 .. [63:56] payload_byte7
	output int          mismatches,
	output int          pending
);

	typedef logic [OUT_FIELDS-1:0][7:0] payload_t;

	// Predicted parser state
	logic [2:0] hunt_phase;
	logic [3:0] bytes_taken;
	byte_t      payload_mem [STORE_DEPTH];

	// Payloads of frames completed but not yet seen on the output
	payload_t   frame_payloads [$];

	int err_count = 0;
	int wait_count = 0;

	assign mismatches = err_count;
	assign pending    = wait_count;

	task automatic report_mismatch(input string msg);
		$display("[%0t] %s", $realtime, msg);
		err_count++;
	endtask

	// Compare one output item with the oldest completed frame
	task automatic check_result(input payload_t got);
		payload_t want;
		if (frame_payloads.size() == 0) begin
			report_mismatch($sformatf("unexpected result item 0x%016h", got));
		end else begin
			want = frame_payloads.pop_front();
			for (int k = 0; k < OUT_FIELDS; k++) begin
				if (got[k] !== want[k])
					report_mismatch($sformatf("payload_byte%0d got 0x%02h want 0x%02h",
						k, got[k], want[k]));
			end
		end
	endtask

	// Advance the predicted hunt by one received byte
	task automatic take_byte(input byte_t b);
		payload_t done;
		case (hunt_phase)
			PH_HUNT: begin
				hunt_phase = (b == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
			end
			PH_HDR2: begin
				hunt_phase = (b == HDR_SECOND) ? PH_LEN : PH_HUNT;
			end
			PH_LEN: begin
				if (b == 8'(PAYLOAD_BYTES)) begin
					bytes_taken = 4'd0;
					hunt_phase  = PH_PAYLOAD;
				end else begin
					hunt_phase = PH_HUNT;
				end
			end
			PH_PAYLOAD: begin
				// bytes past the store are counted only
				if (bytes_taken < STORE_DEPTH)
					payload_mem[bytes_taken[STORE_AW-1:0]] = b;
				bytes_taken = bytes_taken + 4'd1;
				if (bytes_taken == 4'(PAYLOAD_BYTES))
					hunt_phase = PH_MARK;
			end
			PH_MARK: begin
				hunt_phase = (b == END_MARK) ? PH_TRAIL1 : PH_HUNT;
			end
			PH_TRAIL1: begin
				hunt_phase = PH_TRAIL2;
			end
			PH_TRAIL2: begin
				hunt_phase = PH_TRAIL3;
			end
			default: begin
				hunt_phase = PH_HUNT;
				for (int k = 0; k < OUT_FIELDS; k++)
					done[k] = (k < PAYLOAD_BYTES) ? payload_mem[k] : 8'h00;
				frame_payloads.push_back(done);
			end
		endcase
	endtask

	// Results are checked before the byte of the same edge is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hunt_phase  = PH_HUNT;
			bytes_taken = 4'd0;
			for (int k = 0; k < STORE_DEPTH; k++)
				payload_mem[k] = 8'h00;
			frame_payloads.delete();
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (s_tvalid && s_tready)
				take_byte(s_tdata);
		end
		wait_count = frame_payloads.size();
	end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import sfp_pkg::*;

	localparam int PAYLOAD_BYTES = 8;
	localparam int FRAME_LEN     = 3 + PAYLOAD_BYTES + 4;
	localparam int RAND_ITEMS    = 650;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int TAIL_CYCLES   = 20;
	localparam int DIR_LEN       = 23;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [7:0]  s_tdata  = 8'h00;
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [63:0] m_tdata;
	int          mismatches;
	int          pending;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int frame_items    = 0;
	int cycles         = 0;

	byte_t directed_bytes [DIR_LEN];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sonar_frame_parser_core #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	sfp_frame_checker #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES)
	) u_frame_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Receiver back-pressure
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Offer one byte from a falling edge, hold it until accepted
	task automatic send_byte(input byte_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Payload values lean toward the framing bytes now and then
	function automatic byte_t pick_payload();
		case ($urandom_range(7))
			0: return HDR_FIRST;
			1: return END_MARK;
			2: return 8'h00;
			3: return 8'(PAYLOAD_BYTES);
			default: return 8'($urandom);
		endcase
	endfunction

	// Whole frame; spoil_at >= 0 flips bits of that byte
	task automatic send_frame(input int spoil_at);
		byte_t fb [FRAME_LEN];
		fb[0] = HDR_FIRST;
		fb[1] = HDR_SECOND;
		fb[2] = 8'(PAYLOAD_BYTES);
		for (int i = 0; i < PAYLOAD_BYTES; i++)
			fb[3 + i] = pick_payload();
		fb[3 + PAYLOAD_BYTES] = END_MARK;
		for (int i = 4 + PAYLOAD_BYTES; i < FRAME_LEN; i++)
			fb[i] = 8'($urandom);
		if (spoil_at >= 0)
			fb[spoil_at] = fb[spoil_at] ^ 8'($urandom_range(255, 1));
		for (int i = 0; i < FRAME_LEN; i++)
			send_byte(fb[i]);
		frame_items += FRAME_LEN;
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(5, 1);
		for (int i = 0; i < n; i++)
			send_byte(($urandom_range(3) == 0) ? HDR_FIRST : 8'($urandom));
		frame_items += n;
	endtask

	initial begin
		int phase_end;
		int pick;
		int spoil;

		// good frame with framing values in the payload, then broken headers
		directed_bytes = '{8'h55, 8'h54, 8'h08,
			8'h00, 8'hff, 8'h55, 8'h54, 8'h08, 8'hff, 8'h01, 8'h80,
			8'hff, 8'h00, 8'hff, 8'h55,
			8'h55, 8'h54, 8'h09,
			8'h55, 8'h55, 8'h54,
			8'h55, 8'h00};

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_LEN; i++)
			send_byte(directed_bytes[i]);

		// random frames across the idling phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			phase_end = frame_items + RAND_ITEMS / 4;
			while (frame_items < phase_end) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					send_frame(-1);
				end else if (pick < 85) begin
					// spoil a header, length or marker byte
					spoil = $urandom_range(3);
					send_frame((spoil == 3) ? 3 + PAYLOAD_BYTES : spoil);
				end else begin
					send_noise();
				end
			end
		end
		s_tvalid <= 1'b0;

		// drain outstanding results
		while (pending != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: files.f
src/sfp_pkg.sv
src/sonar_frame_parser_core.sv
verif/sfp_frame_checker.sv
verif/tb.sv
